/* src/wipp_pkg.sv */
// ----------------------------------------------------------------------------
// wipp_pkg
// Shared types and codes of the prune planner.
// ----------------------------------------------------------------------------
`default_nettype none
package wipp_pkg;
	typedef enum logic [1:0] {
		CMD_LOAD_REC = 2'd0,
		CMD_LOAD_IMG = 2'd1,
		CMD_LOAD_HOR = 2'd2,
		CMD_RUN      = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_IMG_CHK,
		ST_REC_CHK,
		ST_CH_SETUP,
		ST_CH_LAST,
		ST_CH_IMG,
		ST_CH_BASE,
		ST_CH_START,
		ST_CH_MARK,
		ST_COUNT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_DONE,
		PH_FAIL
	} phase_t;

	typedef struct packed {
		logic       load;
		logic       run_start;
		logic       img_step;
		logic       rec_step;
		logic       ch_setup;
		logic       last_step;
		logic       imgs_step;
		logic       base_step;
		logic       start_step;
		logic       mark_step;
		logic       cnt_init;
		logic       cnt_step;
		logic       fail;
		logic       finish;
	} dp_cmd_t;

	typedef struct packed {
		logic       pre_bad;
		phase_t     img_ph;
		phase_t     rec_ph;
		logic       no_records;
		logic       last_done;
		logic       last_none;
		logic       imgs_done;
		logic       skip_chain;
		logic       base_done;
		logic       start_done;
		logic       chain_fail;
		logic       mark_done;
		logic       more_hor;
		logic       cnt_done;
	} dp_stat_t;
endpackage
`default_nettype wire

/* src/wipp_if.sv */
// ----------------------------------------------------------------------------
// wipp_in_if / wipp_out_if
// Valid/ready channels for input and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface wipp_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [63:0] record_lsn;
	logic [63:0] record_end_lsn;
	logic        record_known;
	logic        record_fpi;
	logic [63:0] image_lsn;
	logic [63:0] horizon_lsn;
	logic [63:0] cutoff_lsn;
	modport source (output valid, cmd, record_lsn, record_end_lsn, record_known,
		record_fpi, image_lsn, horizon_lsn, cutoff_lsn, input ready);
	modport sink (input valid, cmd, record_lsn, record_end_lsn, record_known,
		record_fpi, image_lsn, horizon_lsn, cutoff_lsn, output ready);
endinterface

interface wipp_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [5:0]  kept_count;
	logic [31:0] keep_mask;
	modport source (output valid, status, kept_count, keep_mask, input ready);
	modport sink (input valid, status, kept_count, keep_mask, output ready);
endinterface
`default_nettype wire

/* src/wipp_datapath.sv */
// ----------------------------------------------------------------------------
// wipp_datapath
// Stores, scan counters and the keep mask; one record or image per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wipp_datapath
	import wipp_pkg::*;
#(
	parameter int MAX_RECORDS  = 32,
	parameter int MAX_IMAGES   = 8,
	parameter int MAX_HORIZONS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [1:0]  in_cmd,
	input  wire logic [63:0] in_rec_lsn,
	input  wire logic [63:0] in_rec_end,
	input  wire logic        in_rec_known,
	input  wire logic        in_rec_fpi,
	input  wire logic [63:0] in_img,
	input  wire logic [63:0] in_hor,
	input  wire logic [63:0] in_cutoff,
	output dp_stat_t         stat,
	output logic [5:0]       res_count,
	output logic [31:0]      res_mask
);
	localparam int RW = $clog2(MAX_RECORDS + 1);
	localparam int IW = $clog2(MAX_IMAGES + 1);
	localparam int HW = $clog2(MAX_HORIZONS + 1);
	localparam int RA = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
	localparam int IA = (MAX_IMAGES > 1) ? $clog2(MAX_IMAGES) : 1;
	localparam int HA = (MAX_HORIZONS > 1) ? $clog2(MAX_HORIZONS) : 1;
	localparam int MW = (MAX_RECORDS > 32) ? MAX_RECORDS : 32;

	logic [63:0] rs_q [MAX_RECORDS];
	logic [63:0] re_q [MAX_RECORDS];
	logic        rk_q [MAX_RECORDS];
	logic        ri_q [MAX_RECORDS];
	logic [63:0] im_q [MAX_IMAGES];
	logic [63:0] hz_q [MAX_HORIZONS];
	logic [RW-1:0] rcnt_q;
	logic [IW-1:0] icnt_q;
	logic [HW-1:0] hcnt_q;
	logic          ovf_q;

	logic [63:0] cut_q, h_q, pb_q, prev_q, lend_q;
	logic [RW-1:0] ri_ctr_q;
	logic [IW-1:0] ii_ctr_q;
	logic [HW-1:0] hi_ctr_q;
	logic          hor_phase_q;
	logic [RW-1:0] last_q, base_q, start_q;
	logic          last_v_q, base_v_q, start_v_q, have_q;
	logic          stop_q;
	logic [MW-1:0] keep_q;
	logic [6:0]    cnt_q;

	logic [RA-1:0] r_ix;
	logic [IA-1:0] i_ix;
	logic [HA-1:0] h_ix;
	logic [63:0]   hsel;
	logic [RW-1:0] mark_from;

	assign r_ix = RA'(ri_ctr_q);
	assign i_ix = IA'(ii_ctr_q);
	assign h_ix = HA'(hi_ctr_q);
	assign hsel = (hz_q[h_ix] < cut_q) ? hz_q[h_ix] : cut_q;
	assign mark_from = (have_q && start_v_q && !(base_v_q && base_q > start_q)) ? start_q
		: base_q;

	always_ff @(posedge clk) begin
		if (cmd.load && in_cmd == CMD_LOAD_REC && rcnt_q < RW'(MAX_RECORDS)) begin
			rs_q[RA'(rcnt_q)] <= in_rec_lsn;
			re_q[RA'(rcnt_q)] <= in_rec_end;
			rk_q[RA'(rcnt_q)] <= in_rec_known;
			ri_q[RA'(rcnt_q)] <= in_rec_fpi;
		end
		if (cmd.load && in_cmd == CMD_LOAD_IMG && icnt_q < IW'(MAX_IMAGES))
			im_q[IA'(icnt_q)] <= in_img;
		if (cmd.load && in_cmd == CMD_LOAD_HOR && hcnt_q < HW'(MAX_HORIZONS))
			hz_q[HA'(hcnt_q)] <= in_hor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
			icnt_q <= '0;
			hcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.finish) begin
			rcnt_q <= '0;
			icnt_q <= '0;
			hcnt_q <= '0;
			ovf_q  <= 1'b0;
		end else if (cmd.load) begin
			unique case (cmd_t'(in_cmd))
				CMD_LOAD_REC: if (rcnt_q < RW'(MAX_RECORDS)) rcnt_q <= rcnt_q + 1'b1;
					else ovf_q <= 1'b1;
				CMD_LOAD_IMG: if (icnt_q < IW'(MAX_IMAGES)) icnt_q <= icnt_q + 1'b1;
					else ovf_q <= 1'b1;
				CMD_LOAD_HOR: if (hcnt_q < HW'(MAX_HORIZONS)) hcnt_q <= hcnt_q + 1'b1;
					else ovf_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.run_start) begin
			cut_q    <= in_cutoff;
			ii_ctr_q <= '0;
			ri_ctr_q <= '0;
			hi_ctr_q <= '0;
			hor_phase_q <= 1'b0;
			keep_q   <= '0;
			lend_q   <= '0;
		end
		if (cmd.img_step) begin
			prev_q   <= im_q[i_ix];
			ii_ctr_q <= ii_ctr_q + 1'b1;
		end
		if (cmd.rec_step) begin
			prev_q   <= rs_q[r_ix];
			if (rk_q[r_ix]) lend_q <= re_q[r_ix];
			if ((!rk_q[r_ix] && rs_q[r_ix] > cut_q) || (rk_q[r_ix] && re_q[r_ix] > cut_q))
				keep_q[r_ix] <= 1'b1;
			ri_ctr_q <= ri_ctr_q + 1'b1;
		end
		if (cmd.ch_setup) begin
			h_q       <= hor_phase_q ? hsel : cut_q;
			ri_ctr_q  <= '0;
			ii_ctr_q  <= '0;
			last_v_q  <= 1'b0;
			have_q    <= 1'b0;
			stop_q    <= 1'b0;
			base_v_q  <= 1'b0;
			start_v_q <= 1'b0;
			if (hor_phase_q) hi_ctr_q <= hi_ctr_q + 1'b1;
			hor_phase_q <= 1'b1;
		end
		if (cmd.last_step) begin
			if (rk_q[r_ix]) begin
				if (re_q[r_ix] <= h_q) begin
					last_q <= ri_ctr_q;
					last_v_q <= 1'b1;
				end else if (rs_q[r_ix] > h_q) stop_q <= 1'b1;
			end
			ri_ctr_q <= ri_ctr_q + 1'b1;
		end
		if (cmd.imgs_step) begin
			if (!stat.imgs_done && im_q[i_ix] <= h_q) begin
				have_q <= 1'b1;
				pb_q <= im_q[i_ix];
			end
			ii_ctr_q <= ii_ctr_q + 1'b1;
			ri_ctr_q <= last_q;
		end
		if (cmd.base_step) begin
			if (ri_q[r_ix]) begin
				base_q <= ri_ctr_q;
				base_v_q <= 1'b1;
			end
			ri_ctr_q <= stat.base_done ? '0 : ri_ctr_q - 1'b1;
		end
		if (cmd.start_step) begin
			if (!stat.start_done && rk_q[r_ix] && re_q[r_ix] > pb_q) begin
				start_q <= ri_ctr_q;
				start_v_q <= 1'b1;
			end
			ri_ctr_q <= stat.start_done ? mark_from : ri_ctr_q + 1'b1;
		end
		if (cmd.mark_step) begin
			keep_q[r_ix] <= 1'b1;
			if (!cmd.cnt_init) ri_ctr_q <= ri_ctr_q + 1'b1;
		end
		if (cmd.cnt_init) begin
			ri_ctr_q <= '0;
			cnt_q    <= '0;
		end
		if (cmd.cnt_step) begin
			cnt_q <= cnt_q + {6'd0, keep_q[r_ix]};
			ri_ctr_q <= ri_ctr_q + 1'b1;
		end
		if (cmd.fail) begin
			res_count <= '0;
			res_mask  <= '0;
		end
		if (stat.cnt_done && cmd.cnt_step) begin
			res_count <= cnt_q[5:0];
			res_mask  <= keep_q[31:0];
		end
	end

	always_comb begin
		stat = '0;
		stat.pre_bad = ovf_q || cut_q == 64'd0;
		stat.img_ph = PH_SCAN;
		if (ii_ctr_q >= icnt_q) stat.img_ph = PH_DONE;
		else if (im_q[i_ix] == 64'd0 || (ii_ctr_q != '0 && im_q[i_ix] <= prev_q))
			stat.img_ph = PH_FAIL;
		stat.rec_ph = PH_SCAN;
		if (ri_ctr_q >= rcnt_q) stat.rec_ph = PH_DONE;
		else if ((ri_ctr_q != '0 && rs_q[r_ix] <= prev_q) ||
			(rk_q[r_ix] && re_q[r_ix] <= rs_q[r_ix]) ||
			(rk_q[r_ix] && lend_q != 64'd0 && re_q[r_ix] <= lend_q) ||
			(!rk_q[r_ix] && re_q[r_ix] != 64'd0) ||
			(ri_q[r_ix] && !rk_q[r_ix]) ||
			(!rk_q[r_ix] && rs_q[r_ix] <= cut_q))
			stat.rec_ph = PH_FAIL;
		stat.no_records = rcnt_q == '0;
		stat.last_done  = stop_q || ri_ctr_q >= rcnt_q;
		stat.last_none  = !last_v_q;
		stat.imgs_done  = ii_ctr_q >= icnt_q;
		stat.skip_chain = have_q && re_q[RA'(last_q)] <= pb_q;
		stat.base_done  = base_v_q || ri_ctr_q == '0 || ri_q[r_ix];
		stat.start_done = start_v_q || ri_ctr_q > last_q;
		stat.chain_fail = have_q ? !start_v_q : !base_v_q;
		stat.mark_done  = ri_ctr_q >= last_q;
		stat.more_hor   = hi_ctr_q < hcnt_q;
		stat.cnt_done   = ri_ctr_q >= rcnt_q;
	end
endmodule
`default_nettype wire

/* src/wal_index_prune_planner.sv */
// A load word is accepted every cycle while idle and no result is waiting.
// During a run the controller walks one entry per cycle over the I images,
// R records and H horizons.
// The result sits in an output register until taken; input stalls meanwhile.
// Reset clears the list counts and overflow; stores hold no reset value.
// ----------------------------------------------------------------------------
// wal_index_prune_planner
// Top level: controller sequences datapath scans for a run.
// ----------------------------------------------------------------------------
`default_nettype none
module wal_index_prune_planner
	import wipp_pkg::*;
#(
	parameter int MAX_RECORDS  = 32,
	parameter int MAX_IMAGES   = 8,
	parameter int MAX_HORIZONS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	wipp_in_if.sink  in_ch,
	wipp_out_if.source out_ch
);
	state_t   st_q, st_n;
	dp_cmd_t  c;
	dp_stat_t s;
	logic     status_q, ov_q;
	logic [5:0]  cnt;
	logic [31:0] mask;

	wipp_datapath #(.MAX_RECORDS(MAX_RECORDS), .MAX_IMAGES(MAX_IMAGES),
		.MAX_HORIZONS(MAX_HORIZONS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(c), .in_cmd(in_ch.cmd),
		.in_rec_lsn(in_ch.record_lsn), .in_rec_end(in_ch.record_end_lsn),
		.in_rec_known(in_ch.record_known), .in_rec_fpi(in_ch.record_fpi),
		.in_img(in_ch.image_lsn), .in_hor(in_ch.horizon_lsn),
		.in_cutoff(in_ch.cutoff_lsn), .stat(s), .res_count(cnt), .res_mask(mask));

	wire acc = in_ch.valid && in_ch.ready;
	assign in_ch.ready = st_q == ST_IDLE && !ov_q;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:     if (acc && in_ch.cmd == CMD_RUN) st_n = ST_IMG_CHK;
			ST_IMG_CHK:  if (s.pre_bad || s.img_ph == PH_FAIL) st_n = ST_OUT;
				else if (s.img_ph == PH_DONE) st_n = s.no_records ? ST_COUNT : ST_REC_CHK;
			ST_REC_CHK:  if (s.rec_ph == PH_FAIL) st_n = ST_OUT;
				else if (s.rec_ph == PH_DONE) st_n = ST_CH_SETUP;
			ST_CH_SETUP: st_n = ST_CH_LAST;
			ST_CH_LAST:  if (s.last_done) st_n = s.last_none ? ST_CH_MARK : ST_CH_IMG;
			ST_CH_IMG:   if (s.imgs_done) st_n = ST_CH_BASE;
			ST_CH_BASE:  if (s.skip_chain) st_n = ST_CH_MARK;
				else if (s.base_done) st_n = ST_CH_START;
			ST_CH_START: if (s.start_done) st_n = s.chain_fail ? ST_OUT : ST_CH_MARK;
			ST_CH_MARK:  if (s.last_none || s.skip_chain || s.mark_done)
				st_n = s.more_hor ? ST_CH_SETUP : ST_COUNT;
			ST_COUNT:    if (s.cnt_done) st_n = ST_OUT;
			ST_OUT:      st_n = ST_IDLE;
			default:     st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		c = '0;
		c.load = acc && in_ch.cmd != CMD_RUN;
		c.run_start = acc && in_ch.cmd == CMD_RUN;
		unique case (st_q)
			ST_IMG_CHK:  c.img_step = !s.pre_bad && s.img_ph == PH_SCAN;
			ST_REC_CHK:  c.rec_step = s.rec_ph == PH_SCAN;
			ST_CH_SETUP: c.ch_setup = 1'b1;
			ST_CH_LAST:  c.last_step = !s.last_done;
			ST_CH_IMG:   c.imgs_step = 1'b1;
			ST_CH_BASE:  c.base_step = !s.skip_chain;
			ST_CH_START: c.start_step = 1'b1;
			ST_CH_MARK:  c.mark_step = !(s.last_none || s.skip_chain);
			ST_COUNT:    c.cnt_step = 1'b1;
			ST_OUT:      c.finish = 1'b1;
			default: ;
		endcase
		c.cnt_init = st_n == ST_COUNT && st_q != ST_COUNT;
		c.fail = st_n == ST_OUT && st_q != ST_COUNT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
			status_q <= 1'b0;
		end else begin
			st_q <= st_n;
			if (c.fail) status_q <= 1'b1;
			if (c.run_start) status_q <= 1'b0;
			if (st_q == ST_OUT) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	assign out_ch.valid = ov_q;
	assign out_ch.status = status_q;
	assign out_ch.kept_count = cnt;
	assign out_ch.keep_mask = mask;

`ifndef SYNTH
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_OUT |=> out_ch.valid) else $error("result lost");
	a_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status |-> out_ch.keep_mask == '0)
		else $error("mask on invalid");
`endif
endmodule
`default_nettype wire
